>>> src/least_covered_area_assigner_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least covered area assigner
// Shared forms for clocked properties that use clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef LEAST_COVERED_AREA_ASSIGNER_CORE_ASSERT_SVH
`define LEAST_COVERED_AREA_ASSIGNER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCAA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcaa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcaa assertion failed");

`endif

>>> src/lcaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcaa_pkg
// Shared constants, the scan token type and helpers of the area assigner.
// ----------------------------------------------------------------------------
package lcaa_pkg;

  localparam int MaxAreas  = 64;
  localparam int NumRobots = 2;
  localparam int AreaW     = 7;
  localparam int CountW    = 16;
  localparam int RobotW    = $clog2(NumRobots);

  localparam logic [AreaW-1:0] NumAreasReset = AreaW'(10);

  // Token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [AreaW-1:0]  pos;      // area number of the cell that sees it
    logic [AreaW-1:0]  n;        // areas in use
    logic              wr_en;    // store wr_cnt into area wr_area
    logic [AreaW-1:0]  wr_area;
    logic [CountW-1:0] wr_cnt;
    logic              found;    // best and sel hold a candidate
    logic [CountW-1:0] best;
    logic [AreaW-1:0]  sel;
  } token_t;

  // Number of areas in use: a zero acts as one, large values saturate.
  function automatic logic [AreaW-1:0] areas_in_use(input logic [AreaW-1:0] v);
    logic [AreaW-1:0] r;
    r = v;
    if (v == '0) begin
      r = AreaW'(1);
    end else if (v > AreaW'(MaxAreas)) begin
      r = AreaW'(MaxAreas);
    end
    return r;
  endfunction

endpackage

>>> src/lcaa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcaa_cell
// One area count plus one stage of the running minimum search.
// ----------------------------------------------------------------------------
module lcaa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  lcaa_pkg::token_t tok_i,
  output lcaa_pkg::token_t tok_o
);

  logic [lcaa_pkg::CountW-1:0] count_q, count_d;
  lcaa_pkg::token_t            tok_q, tok_d;
  logic                        hit;
  logic                        in_use;
  logic                        take;
  logic [lcaa_pkg::CountW-1:0] val;

  always_comb begin
    hit    = tok_i.valid && tok_i.wr_en && (tok_i.wr_area == tok_i.pos);
    val    = hit ? tok_i.wr_cnt : count_q;
    in_use = tok_i.pos <= tok_i.n;
    take   = tok_i.valid && in_use && (!tok_i.found || (val < tok_i.best));

    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (hit) begin
      count_d = tok_i.wr_cnt;
    end

    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + 1'b1;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.best  = val;
      tok_d.sel   = tok_i.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tok_q   <= '0;
    end else begin
      count_q <= count_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/least_covered_area_assigner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_covered_area_assigner_core
// Stores a report's count and assigns the robot to the least covered area.
// ----------------------------------------------------------------------------
// A report is one transaction: it is taken when start_i is high while busy_o
// is low, and it yields exactly one result. The result sits on next_area_o,
// min_count_o and previous_area_o for a single cycle with result_valid_o
// high; the receiver cannot stall it, so it must take it then. Timing is set
// by the row of 64 area cells: a scan token enters the first cell on the
// accepting edge and is registered in each cell in turn up to the last one,
// the result register is loaded from the last cell, and busy_o falls at the
// edge that ends the result cycle, so reports are handled one at a time and a
// new one is taken only once the previous result has been shown.
// The num_areas register is written through the cfg_valid_i / cfg_ready_o
// transaction while the block is idle and no report is offered; a write
// clears every area count at once and puts robot 0 back in area 1 and robot 1
// in the last area in use.
// ----------------------------------------------------------------------------
module least_covered_area_assigner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcaa_pkg::AreaW-1:0]    cfg_num_areas_i,
  // Report command
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [lcaa_pkg::RobotW-1:0]   robot_id_i,
  input  logic [lcaa_pkg::CountW-1:0]   grid_count_i,
  // Result strobe
  output logic                          result_valid_o,
  output logic [lcaa_pkg::AreaW-1:0]    next_area_o,
  output logic [lcaa_pkg::CountW-1:0]   min_count_o,
  output logic [lcaa_pkg::AreaW-1:0]    previous_area_o
);

  localparam int MaxAreas  = lcaa_pkg::MaxAreas;
  localparam int NumRobots = lcaa_pkg::NumRobots;

  logic                             busy_q;
  logic                             result_valid_q;
  logic [lcaa_pkg::AreaW-1:0]       num_areas_q;
  logic [lcaa_pkg::AreaW-1:0]       robot_area_q [NumRobots];
  logic [lcaa_pkg::RobotW-1:0]      rid_q;
  logic [lcaa_pkg::AreaW-1:0]       prev_q;
  logic [lcaa_pkg::AreaW-1:0]       next_area_q;
  logic [lcaa_pkg::CountW-1:0]      min_count_q;
  logic [lcaa_pkg::AreaW-1:0]       prev_out_q;

  logic                             accept;
  logic                             cfg_write;
  logic [lcaa_pkg::AreaW-1:0]       n_in_use;
  logic [lcaa_pkg::AreaW-1:0]       prev_area;
  lcaa_pkg::token_t                 tok [MaxAreas+1];

  // A report offered in the same cycle takes precedence over a write, so the
  // two never land on the same edge.
  assign accept      = start_i && !busy_q;
  assign cfg_ready_o = !busy_q && !start_i;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign n_in_use    = lcaa_pkg::areas_in_use(num_areas_q);
  assign prev_area   = robot_area_q[robot_id_i];

  // The token starts at area 1 and carries the store request along, so the
  // reported count lands in the robot's cell just as the scan reaches it.
  always_comb begin
    tok[0].valid   = accept;
    tok[0].pos     = lcaa_pkg::AreaW'(1);
    tok[0].n       = n_in_use;
    tok[0].wr_en   = (prev_area != '0) && (prev_area <= n_in_use);
    tok[0].wr_area = prev_area;
    tok[0].wr_cnt  = grid_count_i;
    tok[0].found   = 1'b0;
    tok[0].best    = '0;
    tok[0].sel     = '0;
  end

  // One cell per area; cells beyond the areas in use let the token pass.
  for (genvar g = 0; g < MaxAreas; g++) begin : g_cell
    lcaa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (cfg_write),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  // Control state: busy flag, result strobe, register and robot areas.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      result_valid_q <= 1'b0;
      num_areas_q    <= lcaa_pkg::NumAreasReset;
      for (int r = 0; r < NumRobots; r++) begin
        robot_area_q[r] <= '0;
      end
      robot_area_q[0] <= lcaa_pkg::AreaW'(1);
      robot_area_q[1] <= lcaa_pkg::areas_in_use(lcaa_pkg::NumAreasReset);
    end else begin
      result_valid_q <= tok[MaxAreas].valid;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (result_valid_q) begin
        busy_q <= 1'b0;
      end
      if (tok[MaxAreas].valid) begin
        robot_area_q[rid_q] <= tok[MaxAreas].sel;
      end
      if (cfg_write) begin
        num_areas_q <= cfg_num_areas_i;
        for (int r = 0; r < NumRobots; r++) begin
          robot_area_q[r] <= '0;
        end
        robot_area_q[0] <= lcaa_pkg::AreaW'(1);
        robot_area_q[1] <= lcaa_pkg::areas_in_use(cfg_num_areas_i);
      end
    end
  end

  // Payload registers of the current transaction and of its result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rid_q  <= robot_id_i;
      prev_q <= prev_area;
    end
    if (tok[MaxAreas].valid) begin
      next_area_q <= tok[MaxAreas].sel;
      min_count_q <= tok[MaxAreas].best;
      prev_out_q  <= prev_q;
    end
  end

  assign busy_o          = busy_q;
  assign result_valid_o  = result_valid_q;
  assign next_area_o     = next_area_q;
  assign min_count_o     = min_count_q;
  assign previous_area_o = prev_out_q;

endmodule

>>> src/lcaa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcaa_checker
// Port-level checks of the area assigner, bound to the top level.
// ----------------------------------------------------------------------------
`include "least_covered_area_assigner_core_assert.svh"

module lcaa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        result_valid_o,
  input logic [lcaa_pkg::AreaW-1:0]  next_area_o
);

  // An accepted report sets busy_o.
  `LCAA_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  // A result only appears for a report in flight.
  `LCAA_ASSERT_SAME(a_result_busy, result_valid_o, busy_o)
  // The block goes idle right after the result cycle.
  `LCAA_ASSERT_NEXT(a_result_idle, result_valid_o, !busy_o && !result_valid_o)
  // The chosen area is always a real area number.
  `LCAA_ASSERT_SAME(a_area_range, result_valid_o,
                    (next_area_o != '0) && (next_area_o <= lcaa_pkg::AreaW'(lcaa_pkg::MaxAreas)))

endmodule

bind least_covered_area_assigner_core lcaa_checker u_lcaa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .next_area_o    (next_area_o)
);
